@@ rtl/lrs_pkg.sv @@
`default_nettype none

package lrs_pkg;

   // run cap: results caused by one input beat
   localparam int MAX_RESULTS = 64;
   localparam int COUNT_BITS  = 7;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEP          = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_OUTPUT_LENGTH = 1'b1;

   // datapath operation codes
   typedef logic [3:0] dp_op_type;
   localparam dp_op_type DP_IDLE  = 4'd0;
   localparam dp_op_type DP_LOAD  = 4'd1;
   localparam dp_op_type DP_MUL_A = 4'd2;
   localparam dp_op_type DP_MUL_B = 4'd3;
   localparam dp_op_type DP_ACC   = 4'd4;
   localparam dp_op_type DP_MAG   = 4'd5;
   localparam dp_op_type DP_MUL_Q = 4'd6;
   localparam dp_op_type DP_MUL_R = 4'd7;
   localparam dp_op_type DP_ROUND = 4'd8;
   localparam dp_op_type DP_ZERO  = 4'd9;
   localparam dp_op_type DP_EMIT  = 4'd10;
   localparam dp_op_type DP_FIN   = 4'd11;

   // controller to datapath
   typedef struct packed {
      dp_op_type op;
      logic      tail;        // tail phase: interpolate last sample against zero
      logic      phase_zero;  // zero fill phase: position does not advance
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic cap_ok;   // run cap not reached
      logic len_ok;   // fewer outputs sent than output_length
      logic int_ok;   // pending output lies before the current sample
      logic tail_ok;  // pending output lies at or before the last sample
      logic last;     // current beat closes the buffer
      logic be;       // held result completes output_length
   } dp_status_type;

endpackage

`default_nettype wire

@@ rtl/lrs_datapath.sv @@
`default_nettype none

module lrs_datapath #(
   parameter int SAMPLE_BITS = 24,
   parameter int FRAC_BITS   = 16,
   parameter int LENGTH_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [lrs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [((FRAC_BITS+5 > LENGTH_BITS) ? FRAC_BITS+5 : LENGTH_BITS)-1:0] csr_wdata,
   input  logic signed [SAMPLE_BITS-1:0]     in_sample,
   input  logic                              in_last,
   input  lrs_pkg::dp_cmd_type               cmd,
   output lrs_pkg::dp_status_type            status,
   output logic signed [SAMPLE_BITS-1:0]     result_sample
);
   import lrs_pkg::*;

   localparam int STEP_BITS = FRAC_BITS + 5;
   localparam int POS_BITS  = LENGTH_BITS + FRAC_BITS;
   localparam int AW        = ((SAMPLE_BITS > FRAC_BITS) ? SAMPLE_BITS : FRAC_BITS) + 1;
   localparam int BW        = FRAC_BITS + 6;
   localparam int PW        = AW + BW;
   localparam int ACC_W     = SAMPLE_BITS + FRAC_BITS + 1;
   localparam int MAG_W     = SAMPLE_BITS + FRAC_BITS;
   localparam int QS_W      = SAMPLE_BITS + STEP_BITS;
   localparam int T_W       = 2 * FRAC_BITS + 6;
   localparam int SUM_W     = QS_W + 1;
   localparam int RES_W     = SUM_W - FRAC_BITS;

   localparam logic [STEP_BITS-1:0] STEP_ONE = STEP_BITS'(1) << FRAC_BITS;
   localparam logic [FRAC_BITS:0]   W_ONE    = (FRAC_BITS+1)'(1) << FRAC_BITS;
   localparam logic [T_W-1:0]       HALF     = T_W'(1) << (2 * FRAC_BITS - 1);
   localparam logic [RES_W-1:0]     LIM      = RES_W'(1) << (SAMPLE_BITS - 1);

   // configuration
   logic [STEP_BITS-1:0]   step_ff;
   logic [LENGTH_BITS-1:0] len_ff;

   // resampler state
   logic signed [SAMPLE_BITS-1:0] prev_ff, prev_in;
   logic                          have_prev_ff, have_prev_in;
   logic [LENGTH_BITS-1:0]        index_ff, index_in;
   logic [POS_BITS-1:0]           pos_ff, pos_in;
   logic [LENGTH_BITS-1:0]        sent_ff, sent_in;
   logic [COUNT_BITS-1:0]         count_ff, count_in;
   logic                          last_ff, last_in;
   logic                          be_ff, be_in;

   // arithmetic payload
   logic signed [SAMPLE_BITS-1:0] cur_ff, cur_in;
   logic signed [PW-1:0]          prod_ff, prod_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic [MAG_W-1:0]              mag_ff, mag_in;
   logic                          neg_ff, neg_in;
   logic [QS_W-1:0]               qs_ff, qs_in;
   logic signed [SAMPLE_BITS-1:0] result_ff, result_in;

   logic [FRAC_BITS-1:0]    frac;
   logic [FRAC_BITS:0]      w0;
   logic [LENGTH_BITS-1:0]  pos_int;
   logic signed [AW-1:0]    opa;
   logic signed [BW-1:0]    opb;
   logic signed [ACC_W-1:0] acc_abs;
   logic [T_W-1:0]          t_round;
   logic [SUM_W-1:0]        sum;
   logic [RES_W-1:0]        res;
   logic [RES_W-1:0]        res_sat;
   logic [SAMPLE_BITS-1:0]  sat_low;
   logic [LENGTH_BITS-1:0]  sent_next;

   assign frac      = pos_ff[FRAC_BITS-1:0];
   assign w0        = W_ONE - {1'b0, frac};
   assign pos_int   = pos_ff[POS_BITS-1:FRAC_BITS];
   assign sent_next = sent_ff + LENGTH_BITS'(1);

   // shared multiplier operand select
   always_comb begin
      opa = '0;
      opb = '0;
      unique case (cmd.op)
         DP_MUL_A: begin
            opa = cmd.tail ? AW'(cur_ff) : AW'(prev_ff);
            opb = signed'({{(BW-FRAC_BITS-1){1'b0}}, w0});
         end
         DP_MUL_B: begin
            opa = cmd.tail ? '0 : AW'(cur_ff);
            opb = signed'({{(BW-FRAC_BITS){1'b0}}, frac});
         end
         DP_MUL_Q: begin
            opa = signed'({{(AW-SAMPLE_BITS){1'b0}}, mag_ff[MAG_W-1:FRAC_BITS]});
            opb = signed'({{(BW-STEP_BITS){1'b0}}, step_ff});
         end
         DP_MUL_R: begin
            opa = signed'({{(AW-FRAC_BITS){1'b0}}, mag_ff[FRAC_BITS-1:0]});
            opb = signed'({{(BW-STEP_BITS){1'b0}}, step_ff});
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   // rounding and saturation of the scaled magnitude
   always_comb begin
      acc_abs = acc_ff[ACC_W-1] ? -acc_ff : acc_ff;
      t_round = prod_ff[T_W-1:0] + HALF;
      sum     = {1'b0, qs_ff} + SUM_W'(t_round >> FRAC_BITS);
      res     = sum[SUM_W-1:FRAC_BITS];
      if (neg_ff) begin
         res_sat = (res > LIM) ? LIM : res;
      end else begin
         res_sat = (res > LIM - RES_W'(1)) ? LIM - RES_W'(1) : res;
      end
      sat_low = res_sat[SAMPLE_BITS-1:0];
   end

   // next state per command
   always_comb begin
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      index_in     = index_ff;
      pos_in       = pos_ff;
      sent_in      = sent_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      be_in        = be_ff;
      cur_in       = cur_ff;
      prod_in      = opa * opb;
      acc_in       = acc_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      qs_in        = qs_ff;
      result_in    = result_ff;
      unique case (cmd.op)
         DP_LOAD: begin
            cur_in   = in_sample;
            last_in  = in_last;
            count_in = '0;
         end
         DP_MUL_B: acc_in = prod_ff[ACC_W-1:0];
         DP_ACC:   acc_in = acc_ff + prod_ff[ACC_W-1:0];
         DP_MAG: begin
            neg_in = acc_ff[ACC_W-1];
            mag_in = acc_abs[MAG_W-1:0];
         end
         DP_MUL_R: qs_in = prod_ff[QS_W-1:0];
         DP_ROUND: result_in = neg_ff ? signed'(~sat_low + SAMPLE_BITS'(1)) : signed'(sat_low);
         DP_ZERO:  result_in = '0;
         DP_EMIT: begin
            sent_in  = sent_next;
            count_in = count_ff + COUNT_BITS'(1);
            be_in    = (sent_next == len_ff);
            if (!cmd.phase_zero) begin
               pos_in = pos_ff + POS_BITS'(step_ff);
            end
         end
         DP_FIN: begin
            if (last_ff) begin
               prev_in      = '0;
               have_prev_in = 1'b0;
               index_in     = '0;
               pos_in       = '0;
               sent_in      = '0;
            end else begin
               prev_in      = cur_ff;
               have_prev_in = 1'b1;
               index_in     = index_ff + LENGTH_BITS'(1);
            end
         end
         default: begin
            prev_in = prev_ff;
         end
      endcase
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_ONE;
         len_ff       <= '0;
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         index_ff     <= '0;
         pos_ff       <= '0;
         sent_ff      <= '0;
         count_ff     <= '0;
         last_ff      <= 1'b0;
         be_ff        <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         have_prev_ff <= have_prev_in;
         index_ff     <= index_in;
         pos_ff       <= pos_in;
         sent_ff      <= sent_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         be_ff        <= be_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_STEP:          step_ff <= csr_wdata[STEP_BITS-1:0];
               REG_OUTPUT_LENGTH: len_ff  <= csr_wdata[LENGTH_BITS-1:0];
               default:           step_ff <= step_ff;
            endcase
         end
      end
   end

   // arithmetic payload
   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      qs_ff     <= qs_in;
      result_ff <= result_in;
   end

   assign status.cap_ok  = (count_ff < COUNT_BITS'(MAX_RESULTS));
   assign status.len_ok  = (sent_ff < len_ff);
   assign status.int_ok  = have_prev_ff && (pos_int < index_ff);
   assign status.tail_ok = last_ff && (pos_int <= index_ff);
   assign status.last    = last_ff;
   assign status.be      = be_ff;
   assign result_sample  = result_ff;

   // run cap holds
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(MAX_RESULTS))
      else $error("result count beyond run cap");

endmodule

`default_nettype wire

@@ rtl/lrs_controller.sv @@
`default_nettype none

module lrs_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   output logic                   out_valid,
   input  logic                   out_ready,
   input  lrs_pkg::dp_status_type status,
   output lrs_pkg::dp_cmd_type    cmd,
   output logic                   out_run_end,
   output logic                   out_buffer_end
);
   import lrs_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_EVAL = 4'd1;
   localparam logic [3:0] S_MA   = 4'd2;
   localparam logic [3:0] S_MB   = 4'd3;
   localparam logic [3:0] S_ACC  = 4'd4;
   localparam logic [3:0] S_MAG  = 4'd5;
   localparam logic [3:0] S_MQ   = 4'd6;
   localparam logic [3:0] S_MR   = 4'd7;
   localparam logic [3:0] S_RND  = 4'd8;
   localparam logic [3:0] S_ZERO = 4'd9;
   localparam logic [3:0] S_EMIT = 4'd10;
   localparam logic [3:0] S_OUT  = 4'd11;
   localparam logic [3:0] S_FIN  = 4'd12;

   localparam logic [1:0] PH_INT  = 2'd0;
   localparam logic [1:0] PH_TAIL = 2'd1;
   localparam logic [1:0] PH_ZERO = 2'd2;

   logic [3:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic       held_ff, held_in;      // a computed result waits for its run_end flag
   logic       run_end_ff, run_end_in;

   logic       avail;
   logic       go;
   logic       adv;
   logic [3:0] start_state;

   // what the current phase asks for next
   always_comb begin
      avail = status.cap_ok && status.len_ok;
      unique case (phase_ff)
         PH_INT:  go = avail && status.int_ok;
         PH_TAIL: go = avail && status.tail_ok;
         PH_ZERO: go = avail;
         default: go = 1'b0;
      endcase
      adv         = !go && ((phase_ff == PH_INT) ? status.last : (phase_ff == PH_TAIL));
      start_state = (phase_ff == PH_ZERO) ? S_ZERO : S_MA;
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      held_in        = held_ff;
      run_end_in     = run_end_ff;
      cmd.op         = DP_IDLE;
      cmd.tail       = (phase_ff == PH_TAIL);
      cmd.phase_zero = (phase_ff == PH_ZERO);
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cmd.op   = DP_LOAD;
               phase_in = PH_INT;
               held_in  = 1'b0;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (go) begin
               if (held_ff) begin
                  run_end_in = 1'b0;
                  state_in   = S_OUT;
               end else begin
                  state_in = start_state;
               end
            end else if (adv) begin
               phase_in = phase_ff + 2'd1;
            end else if (held_ff) begin
               run_end_in = 1'b1;
               state_in   = S_OUT;
            end else begin
               state_in = S_FIN;
            end
         end
         S_MA: begin
            cmd.op   = DP_MUL_A;
            state_in = S_MB;
         end
         S_MB: begin
            cmd.op   = DP_MUL_B;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.op   = DP_ACC;
            state_in = S_MAG;
         end
         S_MAG: begin
            cmd.op   = DP_MAG;
            state_in = S_MQ;
         end
         S_MQ: begin
            cmd.op   = DP_MUL_Q;
            state_in = S_MR;
         end
         S_MR: begin
            cmd.op   = DP_MUL_R;
            state_in = S_RND;
         end
         S_RND: begin
            cmd.op   = DP_ROUND;
            state_in = S_EMIT;
         end
         S_ZERO: begin
            cmd.op   = DP_ZERO;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            cmd.op   = DP_EMIT;
            held_in  = 1'b1;
            state_in = S_EVAL;
         end
         S_OUT: begin
            if (out_ready) begin
               held_in  = 1'b0;
               state_in = run_end_ff ? S_FIN : start_state;
            end
         end
         S_FIN: begin
            cmd.op   = DP_FIN;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         phase_ff   <= PH_INT;
         held_ff    <= 1'b0;
         run_end_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         held_ff    <= held_in;
         run_end_ff <= run_end_in;
      end
   end

   assign in_ready       = (state_ff == S_IDLE) && !reset;
   assign out_valid      = (state_ff == S_OUT);
   assign out_run_end    = run_end_ff;
   assign out_buffer_end = status.be || (status.last && run_end_ff);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(in_ready && out_valid))
      else $error("input taken while a result beat is offered");

   a_out_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |-> held_ff)
      else $error("result beat offered with nothing held");

   a_emit_then_eval: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |=> (state_ff == S_EVAL) && held_ff)
      else $error("emit did not hold a result for evaluation");

   a_last_beat_fin: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_ready && run_end_ff) |=> (state_ff == S_FIN))
      else $error("run end beat did not close the input");

endmodule

`default_nettype wire

@@ rtl/linear_interp_resampler_core.sv @@
`default_nettype none

// Linear interpolation sample rate converter.
// Input stream (req_): one signed source sample per beat, req_tlast on the
// final sample of a buffer. Result stream (rsp_): zero or more resampled
// samples per input beat; rsp_tuser[0] flags the last result of that input,
// rsp_tuser[1] the final output of the buffer.
// Configuration (csr_): step (index 0, unsigned Q5.16 rate ratio and gain)
// and output_length (index 1); write only while the block is idle.
// An input beat without results passes through evaluation and the finish
// state before the next input is taken (two phase changes first if it closes
// the buffer). Each interpolated result passes through the interpolation
// products, accumulate, magnitude, scaling products, round and emit, plus
// the wait on rsp_tready (zero and emit only for a zero fill result). One
// shared multiplier, four products per interpolated result; at most 64 results per input beat.
// The block takes one input beat at a time; req_tready returns once the last
// result of that beat has been taken and the finish state has passed. A stalled rsp_tready
// holds the result beat and the whole sequencer.
// Reset: synchronous; step returns to 1.0, output_length to zero, and the
// previous sample, position and output count are cleared.
module linear_interp_resampler_core #(
   parameter int SAMPLE_BITS = 24,
   parameter int FRAC_BITS   = 16,
   parameter int LENGTH_BITS = 24
) (
   input  logic clock,
   input  logic reset,
   // configuration write port
   input  logic                               csr_we,
   input  logic [lrs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [((FRAC_BITS+5 > LENGTH_BITS) ? FRAC_BITS+5 : LENGTH_BITS)-1:0] csr_wdata,
   // input stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   req_tdata,  // sample_in
   input  logic                               req_tlast,  // last_in
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]   rsp_tdata,  // sample_out
   output logic [1:0]                         rsp_tuser   // run_end, buffer_end
);
   import lrs_pkg::*;

   localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;

   dp_cmd_type                    cmd;
   dp_status_type                 status;
   logic signed [SAMPLE_BITS-1:0] result_sample;
   logic                          run_end;
   logic                          buffer_end;

   lrs_controller u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .status         (status),
      .cmd            (cmd),
      .out_run_end    (run_end),
      .out_buffer_end (buffer_end)
   );

   lrs_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .in_sample     (signed'(req_tdata[SAMPLE_BITS-1:0])),
      .in_last       (req_tlast),
      .cmd           (cmd),
      .status        (status),
      .result_sample (result_sample)
   );

   // pad the sample with zeros up to whole bytes
   assign rsp_tdata = DW'(unsigned'(result_sample));
   assign rsp_tuser = {buffer_end, run_end};

endmodule

`default_nettype wire
